// File: sv/bfiq_pkg.sv
package bfiq_pkg;

   localparam int MaxBitsDefault   = 65536;
   localparam int MaxHashesDefault = 6;
   localparam int SeedRegs         = 6;
   localparam int ModWidth         = 32;

   localparam logic [3:0] CsrBitCount  = 4'd0;
   localparam logic [3:0] CsrHashCount = 4'd1;
   localparam logic [3:0] CsrSeedBase  = 4'd2;

   typedef struct packed {
      logic        mode;
      logic [7:0]  key_byte;
      logic        key_last;
   } req_type;

   // one finished key: final tail, length, op
   typedef struct packed {
      logic        mode;
      logic [31:0] tail_k;
      logic        tail_any;
      logic [31:0] key_length;
   } job_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage

// File: sv/bfiq_front.sv
module bfiq_front #(
   parameter int MAX_HASHES = bfiq_pkg::MaxHashesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  bfiq_pkg::req_type      in_req,
   input  logic [MAX_HASHES*32-1:0] seeds,
   output logic                   job_valid,
   input  logic                   job_stall,
   output bfiq_pkg::job_type      job,
   output logic [MAX_HASHES*32-1:0] job_hash
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MUL1  = 4'b0010,
      S_MUL2  = 4'b0100,
      S_MIX   = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   bfiq_pkg::req_type req_ff, req_in;
   logic [31:0] k_ff, k_in;
   logic [23:0] tail_ff, tail_in;
   logic [1:0]  fill_ff, fill_in;
   logic [31:0] len_ff, len_in;
   logic        first_ff, first_in;
   logic        blk_ff, blk_in;
   logic [MAX_HASHES*32-1:0] hash_ff, hash_in;
   logic        out_valid_ff, out_valid_in;
   bfiq_pkg::job_type job_ff, job_in;
   logic [MAX_HASHES*32-1:0] jh_ff, jh_in;

   assign in_stall  = (state_ff != S_IDLE) || out_valid_ff;
   assign job_valid = out_valid_ff;
   assign job       = job_ff;
   assign job_hash  = jh_ff;

   always_comb begin
      logic [MAX_HASHES*32-1:0] h;
      logic [31:0] t;
      state_in = state_ff; req_in = req_ff; k_in = k_ff; tail_in = tail_ff;
      fill_in = fill_ff; len_in = len_ff; first_in = first_ff; blk_in = blk_ff;
      hash_in = hash_ff; out_valid_in = out_valid_ff; job_in = job_ff; jh_in = jh_ff;
      t = '0;
      h = first_ff ? seeds : hash_ff;
      if (out_valid_ff && !job_stall) out_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid && !in_stall) begin
               req_in = in_req;
               hash_in = h;
               first_in = 1'b0;
               len_in = len_ff + 32'd1;
               if (fill_ff == 2'd3) begin
                  k_in = {in_req.key_byte, tail_ff};
                  tail_in = '0; fill_in = 2'd0; blk_in = 1'b1;
               end else begin
                  tail_in = tail_ff | (24'(in_req.key_byte) << (8 * fill_ff));
                  fill_in = fill_ff + 2'd1; blk_in = 1'b0;
                  k_in = 32'(tail_in);
               end
               // the tail of a key is scrambled in the back
               state_in = blk_in ? S_MUL1 : (in_req.key_last ? S_MIX : S_IDLE);
            end
         end
         S_MUL1: begin
            k_in = bfiq_pkg::rotl32(k_ff * 32'hcc9e2d51, 15);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            k_in = k_ff * 32'h1b873593;
            state_in = S_MIX;
         end
         S_MIX: begin
            if (blk_ff) begin
               for (int i = 0; i < MAX_HASHES; i++) begin
                  t = bfiq_pkg::rotl32(hash_ff[i*32 +: 32] ^ k_ff, 13);
                  hash_in[i*32 +: 32] = (t * 32'd5) + 32'he6546b64;
               end
            end
            if (req_ff.key_last) begin
               out_valid_in = 1'b1;
               job_in.mode = req_ff.mode;
               job_in.tail_k = k_ff;
               job_in.tail_any = !blk_ff;
               job_in.key_length = len_ff;
               jh_in = blk_ff ? hash_in : hash_ff;
               first_in = 1'b1; len_in = '0; tail_in = '0; fill_in = 2'd0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_valid_ff <= 1'b0; first_ff <= 1'b1;
         len_ff <= '0; tail_ff <= '0; fill_ff <= '0;
      end else begin
         state_ff <= state_in; out_valid_ff <= out_valid_in; first_ff <= first_in;
         len_ff <= len_in; tail_ff <= tail_in; fill_ff <= fill_in;
      end
      req_ff <= req_in; k_ff <= k_in; blk_ff <= blk_in; hash_ff <= hash_in;
      job_ff <= job_in; jh_ff <= jh_in;
   end

endmodule

// File: sv/bfiq_queue.sv
module bfiq_queue #(
   parameter int MAX_HASHES = bfiq_pkg::MaxHashesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  bfiq_pkg::job_type      in_job,
   input  logic [MAX_HASHES*32-1:0] in_hash,
   output logic                   out_valid,
   input  logic                   out_stall,
   output bfiq_pkg::job_type      out_job,
   output logic [MAX_HASHES*32-1:0] out_hash
);

   bfiq_pkg::job_type job_ff [2];
   logic [MAX_HASHES*32-1:0] hash_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;
   assign out_job  = job_ff[rp_ff];
   assign out_hash = hash_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         job_ff[wp_ff] <= in_job;
         hash_ff[wp_ff] <= in_hash;
      end
   end

endmodule

// File: sv/bfiq_back.sv
module bfiq_back #(
   parameter int MAX_BITS   = bfiq_pkg::MaxBitsDefault,
   parameter int MAX_HASHES = bfiq_pkg::MaxHashesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_stall,
   input  bfiq_pkg::job_type      job,
   input  logic [MAX_HASHES*32-1:0] job_hash,
   input  logic [16:0]            bit_count,
   input  logic [2:0]             hash_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_was_query,
   output logic                   rsp_is_member
);

   localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
   localparam int HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
   localparam int MW = $clog2(MAX_BITS + 1);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_SC1   = 10'b0000000100,
      S_SC2   = 10'b0000001000,
      S_FIN0  = 10'b0000010000,
      S_FIN1  = 10'b0000100000,
      S_FIN2  = 10'b0001000000,
      S_MOD   = 10'b0010000000,
      S_MEM   = 10'b0100000000,
      S_CHK   = 10'b1000000000
   } state_type;

   logic        store [MAX_BITS];
   state_type   state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] h_ff, h_in;
   logic [HW-1:0] idx_ff, idx_in;
   logic [2:0]  nh_ff, nh_in;
   logic [MW-1:0] m_ff, m_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  bit_ff, bit_in;
   logic        rd_ff;
   logic        all_ff, all_in;
   logic        wr_en;
   logic        vout_ff, vout_in;
   logic        q_ff, q_in, mem_ff, mem_in;
   logic [32:0] trial;
   bfiq_pkg::job_type jb_ff, jb_in;
   logic [MAX_HASHES*32-1:0] jbh_ff, jbh_in;

   assign job_stall = (state_ff != S_IDLE) || vout_ff;
   assign rsp_valid = vout_ff;
   assign rsp_was_query = q_ff;
   assign rsp_is_member = mem_ff;
   assign trial = {rem_ff, h_ff[31]} - 33'(m_ff);

   always_comb begin
      logic [2:0] nh;
      logic [16:0] m;
      state_in = state_ff; clr_in = clr_ff; k_in = k_ff; h_in = h_ff;
      idx_in = idx_ff; nh_in = nh_ff; m_in = m_ff; rem_in = rem_ff;
      bit_in = bit_ff; all_in = all_ff; wr_en = 1'b0;
      vout_in = vout_ff; q_in = q_ff; mem_in = mem_ff;
      jb_in = jb_ff; jbh_in = jbh_ff;
      if (vout_ff && !rsp_stall) vout_in = 1'b0;
      nh = (hash_count == 3'd0) ? 3'd1 : hash_count;
      if (32'(nh) > MAX_HASHES) nh = 3'(MAX_HASHES);
      m = (bit_count == 17'd0) ? 17'd1 : bit_count;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MAX_BITS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (job_valid && !job_stall) begin
               nh_in = nh;
               m_in = (32'(m) > MAX_BITS) ? MW'(MAX_BITS) : MW'(m);
               idx_in = '0; all_in = 1'b1;
               jb_in = job; jbh_in = job_hash;
               k_in = job.tail_k * 32'hcc9e2d51;
               state_in = S_SC1;
            end
         end
         S_SC1: begin
            k_in = bfiq_pkg::rotl32(k_ff, 15) * 32'h1b873593;
            state_in = S_SC2;
         end
         S_SC2: begin
            h_in = jbh_ff[32*idx_ff +: 32] ^ (jb_ff.tail_any ? k_ff : 32'd0)
                   ^ jb_ff.key_length;
            h_in = h_in ^ (h_in >> 16);
            state_in = S_FIN0;
         end
         S_FIN0: begin
            h_in = h_ff * 32'h85ebca6b;
            h_in = h_in ^ (h_in >> 13);
            state_in = S_FIN1;
         end
         S_FIN1: begin
            h_in = h_ff * 32'hc2b2ae35;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            h_in = h_ff ^ (h_ff >> 16);
            rem_in = '0; bit_in = '0;
            state_in = S_MOD;
         end
         S_MOD: begin
            if (trial[32]) rem_in = {rem_ff[30:0], h_ff[31]};
            else rem_in = trial[31:0];
            h_in = {h_ff[30:0], 1'b0};
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd31) state_in = S_MEM;
         end
         S_MEM: begin
            wr_en = !jb_ff.mode;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (jb_ff.mode && !rd_ff) all_in = 1'b0;
            if (32'(idx_ff) + 1 == 32'(nh_ff)) begin
               vout_in = 1'b1;
               q_in = jb_ff.mode;
               mem_in = jb_ff.mode && all_in;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SC2;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) store[clr_ff[AW-1:0]] <= 1'b0;
      else if (wr_en) store[rem_ff[AW-1:0]] <= 1'b1;
      rd_ff <= store[rem_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; vout_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; vout_ff <= vout_in;
      end
      k_ff <= k_in; h_ff <= h_in; idx_ff <= idx_in; nh_ff <= nh_in; m_ff <= m_in;
      rem_ff <= rem_in; bit_ff <= bit_in; all_ff <= all_in;
      q_ff <= q_in; mem_ff <= mem_in; jb_ff <= jb_in; jbh_ff <= jbh_in;
   end

endmodule

// File: sv/bloom_filter_insert_query.sv
// front: a byte completing a 4-byte block passes MUL1, MUL2 and MIX; others are
// taken in idle, and a key end goes through MIX; the back scrambles the tail, then
// per hash runs finalize multiplies, a 32-step restoring modulo and a store read
// front and back overlap through a two-entry queue
// reset: synchronous; after reset the bit store is cleared one bit a cycle over all
// MAX_BITS bits, during which the back end processes no key end
module bloom_filter_insert_query #(
   parameter int MAX_BITS   = bfiq_pkg::MaxBitsDefault,
   parameter int MAX_HASHES = bfiq_pkg::MaxHashesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_key_byte,
   input  logic        req_key_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_was_query,
   output logic        rsp_is_member,
   input  logic        csr_write,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [16:0] bit_count_ff;
   logic [2:0]  hash_count_ff;
   logic [31:0] seed_ff [bfiq_pkg::SeedRegs];
   logic [MAX_HASHES*32-1:0] seeds;
   bfiq_pkg::req_type req;
   logic fj_valid, fj_stall, bj_valid, bj_stall;
   bfiq_pkg::job_type fj, bj;
   logic [MAX_HASHES*32-1:0] fh, bh;

   always_comb begin
      for (int i = 0; i < MAX_HASHES; i++)
         seeds[i*32 +: 32] = seed_ff[i % bfiq_pkg::SeedRegs];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= 17'd65536;
         hash_count_ff <= 3'd3;
         for (int i = 0; i < bfiq_pkg::SeedRegs; i++) seed_ff[i] <= 32'(i + 1);
      end else if (csr_write) begin
         if (csr_index == bfiq_pkg::CsrBitCount) bit_count_ff <= csr_data[16:0];
         else if (csr_index == bfiq_pkg::CsrHashCount) hash_count_ff <= csr_data[2:0];
         else if (csr_index >= bfiq_pkg::CsrSeedBase &&
                  csr_index < bfiq_pkg::CsrSeedBase + 4'(bfiq_pkg::SeedRegs))
            seed_ff[3'(csr_index - bfiq_pkg::CsrSeedBase)] <= csr_data;
      end
   end

   assign req.mode = req_mode;
   assign req.key_byte = req_key_byte;
   assign req.key_last = req_key_last;

   bfiq_front #(.MAX_HASHES(MAX_HASHES)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_req(req),
      .seeds, .job_valid(fj_valid), .job_stall(fj_stall), .job(fj), .job_hash(fh)
   );

   bfiq_queue #(.MAX_HASHES(MAX_HASHES)) u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_stall(fj_stall), .in_job(fj),
      .in_hash(fh), .out_valid(bj_valid), .out_stall(bj_stall), .out_job(bj),
      .out_hash(bh)
   );

   bfiq_back #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
      .clock, .reset, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
      .job_hash(bh), .bit_count(bit_count_ff), .hash_count(hash_count_ff),
      .rsp_valid, .rsp_stall, .rsp_was_query, .rsp_is_member
   );

endmodule

// File: sv/bfiq_checker.sv
module bfiq_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_was_query,
   input logic rsp_is_member
);

   // insert never reports membership
   a_insert_no_member: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_query |-> !rsp_is_member) else $error("insert member");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_member)
      && $stable(rsp_was_query))
      else $error("response dropped");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response after reset");

   // input side ready right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall) else $error("request stalled after reset");

endmodule

bind bloom_filter_insert_query bfiq_checker u_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_was_query, .rsp_is_member
);
